// File: hw/rtl/piecewise_linear_interpolator_core_macros.svh
// Assertion macros shared by the interpolator RTL.
// PLI_ASSERT_IMP checks a consequent in the same cycle as its antecedent,
// PLI_ASSERT_NXT checks it in the following cycle.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interpolator check failed");

`define PLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interpolator check failed");

`else

`define PLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/pli_pkg.sv
package pli_pkg;

    // Fixed field widths
    localparam int IDX_W   = 4;
    localparam int PROB_W  = 17;
    localparam int SEG_W   = 5;
    localparam int REG_W   = 2;
    localparam int CNT_W   = 5;
    localparam int OUT_W   = 24;

    // Q1.16 one
    localparam logic [PROB_W-1:0] PROB_ONE  = 17'h10000;
    localparam logic [PROB_W-1:0] PROB_ZERO = 17'h00000;

    // Item kinds carried in tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result regions
    localparam logic [REG_W-1:0] REGION_BELOW  = 2'd0;
    localparam logic [REG_W-1:0] REGION_INTERP = 2'd1;
    localparam logic [REG_W-1:0] REGION_BEYOND = 2'd2;

endpackage

// File: hw/rtl/pli_div.sv
`include "piecewise_linear_interpolator_core_macros.svh"

module pli_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEPS = (NUM_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DEN_W-1:0] rem_reg,   rem_next;
    logic [PAD_W-1:0] dvd_reg,   dvd_next;
    logic [DEN_W-1:0] den_reg,   den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem_step;
    logic [PAD_W-1:0] dvd_step;

    // Two restoring steps per cycle, quotient bits shift in at the bottom
    always_comb
    begin
        rem_step = rem_reg;
        dvd_step = dvd_reg;
        trial    = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {rem_step, dvd_step[PAD_W-1]};
            dvd_step = {dvd_step[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial       = trial - {1'b0, den_reg};
                dvd_step[0] = 1'b1;
            end
            rem_step = trial[DEN_W-1:0];
        end
    end

    // Load on start, iterate while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            rem_next  = '0;
            dvd_next  = PAD_W'(num);
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            dvd_next = dvd_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg[NUM_W-1:0];

    `PLI_ASSERT_IMP(a_start_when_idle, clk, rst_n, start, !busy_reg)
    `PLI_ASSERT_IMP(a_rem_below_den, clk, rst_n, busy_reg, rem_reg < den_reg)
    `PLI_ASSERT_NXT(a_done_single, clk, rst_n, done_reg, !done_reg && !busy_reg)

endmodule

// File: hw/rtl/piecewise_linear_interpolator_core.sv
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tuser: func; tdata: entry_index, distance,
//                                        entry_probability
// m_axis    out  m_axis_tvalid/tready    tdata: probability, region, segment
// cfg       in   cfg_wr_en               cfg_wr_data: point_count
//
// A load item writes the table memory at acceptance.
// A query searches the n points in use with one search read per entry, then takes
// one multiply step and the two-bit-per-cycle divider.
// Below-first and empty-table queries skip the multiply and the divider.
// Reset clears the count register and control; the table holds garbage until loaded.
// A result waits in the output register; loads are still taken while it stalls.
`include "piecewise_linear_interpolator_core_macros.svh"

module piecewise_linear_interpolator_core #(
    parameter int MAX_POINTS = 16,
    parameter int DIST_BITS  = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // cfg
    input  logic                                     cfg_wr_en,
    input  logic [pli_pkg::CNT_W-1:0]                cfg_wr_data,
    // input items
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tuser: func
    input  logic                                     s_axis_tuser,
    // tdata: entry_index, distance, entry_probability, zero pad
    input  logic [((DIST_BITS + pli_pkg::IDX_W + pli_pkg::PROB_W + 7) / 8) * 8 - 1:0]
                                                     s_axis_tdata,
    // result items
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // tdata: probability, region, segment
    output logic [pli_pkg::OUT_W-1:0]                m_axis_tdata
);

    import pli_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int ENT_W   = DIST_BITS + PROB_W;
    localparam int PRODS_W = PROB_W + DIST_BITS + 2;
    localparam int MAG_W   = PROB_W + DIST_BITS;
    localparam int SUM_W   = MAG_W + 2;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIVST  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // Input fields
    logic [IDX_W-1:0]     in_idx;
    logic [DIST_BITS-1:0] in_dist;
    logic [PROB_W-1:0]    in_prob;
    logic                 in_acc;

    assign in_idx  = s_axis_tdata[IDX_W-1:0];
    assign in_dist = s_axis_tdata[IDX_W +: DIST_BITS];
    assign in_prob = s_axis_tdata[IDX_W + DIST_BITS +: PROB_W];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // Control state
    logic [2:0]          state_reg,   state_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic                rd_vld_reg,  rd_vld_next;
    logic                m_vld_reg,   m_vld_next;

    // Payload state
    logic [SEG_W-1:0]     n_reg,       n_next;
    logic [DIST_BITS-1:0] q_reg,       q_next;
    logic [SEG_W-1:0]     rd_idx_reg,  rd_idx_next;
    logic [SEG_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [ENT_W-1:0]     prev_reg,    prev_next;
    logic [ENT_W-1:0]     cur_reg,     cur_next;
    logic [SEG_W-1:0]     seg_reg,     seg_next;
    logic [REG_W-1:0]     region_reg,  region_next;
    logic [PROB_W-1:0]    prob_reg,    prob_next;
    logic signed [PRODS_W-1:0] prod_reg, prod_next;
    logic [DIST_BITS-1:0] span_reg,    span_next;
    logic                 neg_reg,     neg_next;
    logic [OUT_W-1:0]     out_reg,     out_next;

    // Table memory: breakpoint in the low bits, probability above
    logic [ENT_W-1:0] tbl_mem [MAX_POINTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             tbl_we;

    // Datapath helpers
    logic [SEG_W-1:0]     n_in;
    logic [DIST_BITS-1:0] rd_bp;
    logic [DIST_BITS-1:0] prev_d, cur_d;
    logic [PROB_W-1:0]    prev_p, cur_p;
    logic signed [PROB_W:0] dp;
    logic [DIST_BITS-1:0] dq;
    logic [PRODS_W-1:0]   mag_full;
    logic                 div_start;
    logic                 div_done;
    logic [MAG_W-1:0]     div_quot;
    logic signed [SUM_W-1:0] sum_p1, sum_q, sum;

    assign tbl_we = in_acc && (s_axis_tuser == FUNC_LOAD) && (32'(in_idx) < MAX_POINTS);

    // Write loads at acceptance, read the search entry every cycle
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[ADDR_W'(in_idx)] <= {in_prob, in_dist};
        end
        rd_data_reg <= tbl_mem[ADDR_W'(rd_idx_reg)];
    end

    // Clamp the count to the table depth
    assign n_in = (32'(count_reg) > MAX_POINTS) ? SEG_W'(MAX_POINTS) : count_reg;

    assign rd_bp  = rd_data_reg[DIST_BITS-1:0];
    assign prev_d = prev_reg[DIST_BITS-1:0];
    assign prev_p = prev_reg[DIST_BITS +: PROB_W];
    assign cur_d  = cur_reg[DIST_BITS-1:0];
    assign cur_p  = cur_reg[DIST_BITS +: PROB_W];

    assign dp = $signed({1'b0, cur_p}) - $signed({1'b0, prev_p});
    assign dq = q_reg - prev_d;

    assign mag_full  = prod_reg[PRODS_W-1] ? $unsigned(-prod_reg) : $unsigned(prod_reg);
    assign div_start = (state_reg == S_DIVST);

    // Signed sum of the left probability and the truncated quotient
    assign sum_p1 = $signed(SUM_W'(prev_p));
    assign sum_q  = $signed({2'b00, div_quot});
    assign sum    = neg_reg ? (sum_p1 - sum_q) : (sum_p1 + sum_q);

    pli_div #(
        .NUM_W (MAG_W),
        .DEN_W (DIST_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mag_full[MAG_W-1:0]),
        .den   (span_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign s_axis_tready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_vld_next  = 1'b0;
        m_vld_next   = m_vld_reg;
        n_next       = n_reg;
        q_next       = q_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = rd_idx_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        seg_next     = seg_reg;
        region_next  = region_reg;
        prob_next    = prob_reg;
        prod_next    = prod_reg;
        span_next    = span_reg;
        neg_next     = neg_reg;
        out_next     = out_reg;

        if (cfg_wr_en)
        begin
            count_next = cfg_wr_data;
        end

        // Drop the result once taken
        if (m_vld_reg && m_axis_tready)
        begin
            m_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (s_axis_tuser == FUNC_QUERY))
                begin
                    q_next      = in_dist;
                    n_next      = n_in;
                    rd_idx_next = '0;
                    if (n_in == '0)
                    begin
                        seg_next    = '0;
                        region_next = REGION_BELOW;
                        prob_next   = PROB_ONE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                // Issue the next read, compare the entry that came back
                rd_idx_next = rd_idx_reg + 1'b1;
                rd_vld_next = 1'b1;
                if (rd_vld_reg)
                begin
                    if (rd_bp > q_reg)
                    begin
                        seg_next    = cmp_idx_reg;
                        rd_vld_next = 1'b0;
                        if (cmp_idx_reg == '0)
                        begin
                            region_next = REGION_BELOW;
                            prob_next   = PROB_ONE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cur_next    = rd_data_reg;
                            region_next = REGION_INTERP;
                            state_next  = S_MUL;
                        end
                    end
                    else
                    begin
                        prev_next = rd_data_reg;
                        if (cmp_idx_reg + 1'b1 == n_reg)
                        begin
                            seg_next    = n_reg;
                            region_next = REGION_BEYOND;
                            prob_next   = PROB_ZERO;
                            rd_vld_next = 1'b0;
                            state_next  = S_DONE;
                        end
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = dp * $signed({1'b0, dq});
                span_next  = cur_d - prev_d;
                state_next = S_DIVST;
            end
            S_DIVST:
            begin
                neg_next   = prod_reg[PRODS_W-1];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Saturate to 0..1
                if (div_done)
                begin
                    if (sum < 0)
                    begin
                        prob_next = PROB_ZERO;
                    end
                    else if (sum > $signed(SUM_W'(PROB_ONE)))
                    begin
                        prob_next = PROB_ONE;
                    end
                    else
                    begin
                        prob_next = sum[PROB_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!m_vld_reg || m_axis_tready)
                begin
                    out_next   = {seg_reg, region_reg, prob_reg};
                    m_vld_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_vld_reg <= rd_vld_next;
            m_vld_reg  <= m_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        q_reg       <= q_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        seg_reg     <= seg_next;
        region_reg  <= region_next;
        prob_reg    <= prob_next;
        prod_reg    <= prod_next;
        span_reg    <= span_next;
        neg_reg     <= neg_next;
        out_reg     <= out_next;
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = out_reg;

    // Assertion terms
    logic chk_cmp, chk_done, chk_below;

    assign chk_cmp   = (state_reg == S_SEARCH) && rd_vld_reg;
    assign chk_done  = (state_reg == S_DONE);
    assign chk_below = chk_done && (region_reg == REGION_BELOW);

    `PLI_ASSERT_IMP(a_cmp_in_range, clk, rst_n, chk_cmp, cmp_idx_reg < n_reg)
    `PLI_ASSERT_IMP(a_seg_bound, clk, rst_n, chk_done, seg_reg <= n_reg)
    `PLI_ASSERT_IMP(a_below_is_one, clk, rst_n, chk_below, (prob_reg == PROB_ONE) && (seg_reg == '0))
    `PLI_ASSERT_IMP(a_interp_span, clk, rst_n, state_reg == S_DIVST, span_reg != '0)

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import pli_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int TOTAL_ITEMS  = 1150;
    localparam int QUIET_FROM   = TOTAL_ITEMS - 150;
    localparam int DRAIN_CYCLES = 48;
    localparam int STALL_LIMIT  = 2000;
    localparam int IN_W         = 40;

    // one result item, probability in the low bits as on m_axis_tdata
    typedef struct packed {
        logic [SEG_W-1:0]  segment;
        logic [REG_W-1:0]  region;
        logic [PROB_W-1:0] probability;
    } interp_result_t;

    // Mirror of the breakpoint table plus the queue of query results still owed
    class pwl_tracker;
        logic [15:0]       breakpoint [TABLE_DEPTH];
        logic [PROB_W-1:0] weight [TABLE_DEPTH];
        logic [CNT_W-1:0]  point_count = '0;
        interp_result_t    pending_results [$];
        int                mismatches = 0;

        function void set_count(logic [CNT_W-1:0] value);
            point_count = value;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Search for the first greater breakpoint, then interpolate and clamp
        function interp_result_t evaluate(logic [15:0] q);
            interp_result_t r;
            int     in_use;
            int     seg;
            longint d1, d2, p1, p2, span, acc;
            in_use = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(point_count);
            seg = 0;
            while (seg < in_use && breakpoint[seg] <= q)
                seg++;
            r.segment = seg[SEG_W-1:0];
            if (seg == 0)
            begin
                r.probability = PROB_ONE;
                r.region      = REGION_BELOW;
            end
            else if (seg == in_use)
            begin
                r.probability = PROB_ZERO;
                r.region      = REGION_BEYOND;
            end
            else
            begin
                d1   = longint'(breakpoint[seg-1]);
                d2   = longint'(breakpoint[seg]);
                p1   = longint'(weight[seg-1]);
                p2   = longint'(weight[seg]);
                span = d2 - d1;
                acc  = p1;
                // product first, then divide truncating toward zero
                if (span > 0)
                    acc = p1 + ((p2 - p1) * (longint'(q) - d1)) / span;
                if (acc < 0)
                    acc = 0;
                if (acc > 65536)
                    acc = 65536;
                r.probability = acc[PROB_W-1:0];
                r.region      = REGION_INTERP;
            end
            return r;
        endfunction

        // Apply a load to the mirror, or queue the result a query will give
        function void note_item(logic func, logic [IDX_W-1:0] idx, logic [15:0] dist_val,
                                logic [PROB_W-1:0] prob);
            if (func == FUNC_LOAD)
            begin
                breakpoint[idx] = dist_val;
                weight[idx]     = prob;
            end
            else
                pending_results.push_back(evaluate(dist_val));
        endfunction

        task report_mismatch(string what, int got_v, int want_v);
            $display("ERROR: %s got %0d expected %0d at %0t", what, got_v, want_v, $time);
            mismatches++;
        endtask

        task check_result(logic [OUT_W-1:0] word);
            interp_result_t got;
            interp_result_t want;
            got = word;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, probability", int'(got.probability), -1);
                return;
            end
            want = pending_results.pop_front();
            if (got.probability != want.probability)
                report_mismatch("probability", int'(got.probability), int'(want.probability));
            if (got.region != want.region)
                report_mismatch("region", int'(got.region), int'(want.region));
            if (got.segment != want.segment)
                report_mismatch("segment", int'(got.segment), int'(want.segment));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic             s_axis_tuser;      // func
    logic [IN_W-1:0]  s_axis_tdata;      // entry_index, distance, entry_probability, pad
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;      // probability, region, segment

    pwl_tracker tracker = new();
    int         items_sent     = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;
    int         quiet_cycles   = 0;

    piecewise_linear_interpolator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Present one item, with an optional idle burst first, and hold until taken
    task automatic push_item(input logic func, input logic [IDX_W-1:0] idx,
                             input logic [15:0] dist_val, input logic [PROB_W-1:0] prob);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {3'b000, prob, dist_val, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.note_item(func, idx, dist_val, prob);
        items_sent++;
    endtask

    // Drain the block, then write the point count while it is idle
    task automatic write_point_count(input logic [CNT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        tracker.set_count(value);
        cfg_wr_en <= 1'b0;
    endtask

    // Result sink with random stall bursts
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Check every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus
    initial
    begin
        logic [CNT_W-1:0]  count_sel;
        logic [15:0]       query_dist;
        logic [PROB_W-1:0] prob;
        int                phase;
        int                budget;
        int                max_step;
        int                cur;
        int                pmode;
        int                pick;
        int                in_use;
        longint            near_v;

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= FUNC_LOAD;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: any distance gives one
        write_point_count(5'd0);
        push_item(FUNC_QUERY, 4'd0, 16'h0000, 17'h00000);
        push_item(FUNC_QUERY, 4'hF, 16'hFFFF, 17'h1FFFF);

        // Four points, one stored probability above one
        write_point_count(5'd4);
        push_item(FUNC_LOAD, 4'd0, 16'h0100, 17'h10000);
        push_item(FUNC_LOAD, 4'd1, 16'h0200, 17'h1FFFF);
        push_item(FUNC_LOAD, 4'd2, 16'h8000, 17'h08000);
        push_item(FUNC_LOAD, 4'd3, 16'hFFFF, 17'h00000);
        push_item(FUNC_QUERY, 4'd0, 16'h0000, 17'h0);
        push_item(FUNC_QUERY, 4'd0, 16'h00FF, 17'h0);
        push_item(FUNC_QUERY, 4'd0, 16'h0100, 17'h0);
        push_item(FUNC_QUERY, 4'd0, 16'h0180, 17'h0);
        push_item(FUNC_QUERY, 4'd0, 16'h0200, 17'h0);
        push_item(FUNC_QUERY, 4'd0, 16'h4000, 17'h0);
        push_item(FUNC_QUERY, 4'd0, 16'hFFFE, 17'h0);
        push_item(FUNC_QUERY, 4'd0, 16'hFFFF, 17'h0);

        // Break the ordering: the search still stops at the first greater point
        push_item(FUNC_LOAD, 4'd2, 16'h0050, 17'h0C000);
        push_item(FUNC_QUERY, 4'd0, 16'h0150, 17'h0);
        push_item(FUNC_QUERY, 4'd0, 16'h0300, 17'h0);

        // Single point: below it or beyond it, nothing between
        write_point_count(5'd1);
        push_item(FUNC_QUERY, 4'd0, 16'h00FF, 17'h0);
        push_item(FUNC_QUERY, 4'd0, 16'h0100, 17'h0);

        // Random phases: new count, mostly a fresh sorted table, then queries
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 2);
            src_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
            pick = $urandom_range(0, 2);
            sink_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
            if (items_sent >= QUIET_FROM)
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end

            pick = $urandom_range(0, 9);
            if (phase == 0)
                count_sel = 5'd16;
            else if (phase == 1)
                count_sel = 5'd31;
            else if (pick == 0)
                count_sel = 5'd0;
            else if (pick == 1)
                count_sel = 5'd1;
            else if (pick == 2)
                count_sel = 5'd16;
            else if (pick == 3)
                count_sel = 5'($urandom_range(17, 31));
            else
                count_sel = 5'($urandom_range(2, 15));
            write_point_count(count_sel);

            // Reload all entries strictly increasing; the first phase always does
            if (phase == 0 || $urandom_range(0, 9) < 6)
            begin
                if ($urandom_range(0, 3) == 0)
                    max_step = $urandom_range(1, 8);
                else
                    max_step = $urandom_range(1, 4095);
                cur   = $urandom_range(0, 65535 - 16 * max_step);
                pmode = $urandom_range(0, 2);
                for (int k = 0; k < TABLE_DEPTH; k++)
                begin
                    if (k != 0)
                        cur = cur + $urandom_range(1, max_step);
                    if (pmode == 0)
                        prob = 17'($urandom_range(0, 65536));
                    else if (pmode == 1)
                        prob = 17'($urandom_range(0, 17'h1FFFF));
                    else
                        prob = 17'(65536 - k * 4369);
                    push_item(FUNC_LOAD, 4'(k), 16'(cur), prob);
                end
            end

            budget = $urandom_range(30, 80);
            for (int k = 0; k < budget && items_sent < TOTAL_ITEMS; k++)
            begin
                if (items_sent >= QUIET_FROM)
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray load with arbitrary content
                    push_item(FUNC_LOAD, 4'($urandom_range(0, 15)), 16'($urandom),
                              17'($urandom_range(0, 17'h1FFFF)));
                end
                else
                begin
                    in_use = (tracker.point_count > TABLE_DEPTH) ? TABLE_DEPTH
                                                                 : int'(tracker.point_count);
                    pick = $urandom_range(0, 9);
                    if (pick < 4 && in_use > 0)
                    begin
                        // land on or next to a breakpoint in use
                        near_v = longint'(tracker.breakpoint[$urandom_range(0, in_use - 1)])
                                 + longint'($urandom_range(0, 4)) - 2;
                        if (near_v < 0)
                            near_v = 0;
                        if (near_v > 65535)
                            near_v = 65535;
                        query_dist = near_v[15:0];
                    end
                    else if (pick == 4)
                        query_dist = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                    else
                        query_dist = 16'($urandom);
                    push_item(FUNC_QUERY, 4'($urandom_range(0, 15)), query_dist,
                              17'($urandom_range(0, 17'h1FFFF)));
                end
            end
            phase++;
        end

        // Wait for the last results, then let the block settle
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
